FILE: rtl/core/cppt_pkg.sv
// Package for the convex polygon point test block.
// Holds the sequencer state type, the fixed result width and the control
// and status structs shared by the top level and the edge datapath.
package cppt_pkg;

  // Width of the reported twice-area field
  localparam int unsigned AREA_BITS = 34;

  // Item kinds carried on the mode field
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_ACC,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // Controls from the sequencer to the edge datapath
  typedef struct packed {
    logic clr_part;  // start a new polygon: clear the shoelace sum
    logic load_mul;  // form the shoelace product of last and new vertex
    logic load_acc;  // add the registered product to the shoelace sum
    logic start;     // query start: seed previous vertex, clear triangle sum
    logic rd_valid;  // vertex read data valid this cycle
    logic rd_first;  // the read data is vertex 0 (closing edge)
  } edge_ctrl_t;

  // Status from the edge datapath
  typedef struct packed {
    logic                 busy;     // edge terms still in flight
    logic                 in_poly;  // triangle sum equals polygon twice-area
    logic [AREA_BITS-1:0] area;     // saturated absolute twice-area
  } edge_stat_t;

endpackage

FILE: rtl/core/cppt_in_if.sv
// Input channel of the convex polygon point test block.
// Carries valid, ready and one load or query item; no package dependency.
interface cppt_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic                         first;
  logic signed [COORD_BITS-1:0] x;
  logic signed [COORD_BITS-1:0] y;

  modport source (output valid, output mode, output first, output x, output y,
                  input ready);
  modport sink   (input valid, input mode, input first, input x, input y,
                  output ready);
endinterface

FILE: rtl/core/cppt_out_if.sv
// Output channel of the convex polygon point test block.
// Carries valid, ready and one query result; depends on cppt_pkg for widths.
interface cppt_out_if;
  logic                           valid;
  logic                           ready;
  logic                           inside_res;
  logic                           empty_res;
  logic                           overflowed;
  logic [cppt_pkg::AREA_BITS-1:0] twice_area;

  modport source (output valid, output inside_res, output empty_res,
                  output overflowed, output twice_area, input ready);
  modport sink   (input valid, input inside_res, input empty_res,
                  input overflowed, input twice_area, output ready);
endinterface

FILE: rtl/core/cppt_vertex_store.sv
// Vertex memory of the convex polygon point test block.
// One write port, one read port with registered read data; no dependencies.
module cppt_vertex_store #(
  parameter int DEPTH     = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_BITS-1:0]     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_BITS-1:0]     rdata_o
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  // Write a vertex
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read: data appears in the cycle after the read enable
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cppt_edge_unit.sv
// Edge datapath of the convex polygon point test block: shoelace and
// triangle products, absolute values and sums. Depends on cppt_pkg.
module cppt_edge_unit #(
  parameter int COORD_BITS = 16,
  parameter int CNT_BITS   = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cppt_pkg::edge_ctrl_t         ctrl_i,
  input  logic signed [COORD_BITS-1:0] p_x_i,
  input  logic signed [COORD_BITS-1:0] p_y_i,
  input  logic signed [COORD_BITS-1:0] last_x_i,
  input  logic signed [COORD_BITS-1:0] last_y_i,
  input  logic signed [COORD_BITS-1:0] rd_x_i,
  input  logic signed [COORD_BITS-1:0] rd_y_i,
  output cppt_pkg::edge_stat_t         stat_o
);

  localparam int DB = COORD_BITS + 1;      // sum or difference of two coordinates
  localparam int PB = 2 * DB;              // product of two of those
  localparam int SB = PB + CNT_BITS;       // sum over every edge
  localparam int AB = cppt_pkg::AREA_BITS;
  localparam int WB = (SB > AB) ? SB : AB + 1;

  logic signed [COORD_BITS-1:0] wprev_x_q, wprev_y_q;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, prv_x, prv_y;
  logic signed [DB-1:0]         sh_a, sh_b, t1_a, t1_b, t2_a, t2_b;
  logic signed [PB-1:0]         sh_prod, m1_prod, m2_prod;
  logic signed [PB-1:0]         sh_q, m1_q, m2_q;
  logic signed [PB:0]           diff;
  logic signed [PB:0]           diff_abs;
  logic [PB-1:0]                abs_q;
  logic signed [SB-1:0]         part_q, sum_q, sum_abs;
  logic [SB-1:0]                tri_q, area_q;
  logic [WB-1:0]                area_ext;
  logic                         s1_v_q, s1_f_q, s2_v_q, s2_f_q;

  // Select operands: a load pairs the last vertex with the new one, a walk
  // pairs the previous stored vertex with the one just read
  assign cur_x = ctrl_i.load_mul ? p_x_i    : rd_x_i;
  assign cur_y = ctrl_i.load_mul ? p_y_i    : rd_y_i;
  assign prv_x = ctrl_i.load_mul ? last_x_i : wprev_x_q;
  assign prv_y = ctrl_i.load_mul ? last_y_i : wprev_y_q;

  assign sh_a = DB'(prv_x) + DB'(cur_x);
  assign sh_b = DB'(prv_y) - DB'(cur_y);
  assign t1_a = DB'(wprev_x_q) - DB'(p_x_i);
  assign t1_b = DB'(rd_y_i) - DB'(wprev_y_q);
  assign t2_a = DB'(wprev_x_q) - DB'(rd_x_i);
  assign t2_b = DB'(p_y_i) - DB'(wprev_y_q);

  assign sh_prod = PB'(sh_a) * PB'(sh_b);
  assign m1_prod = PB'(t1_a) * PB'(t1_b);
  assign m2_prod = PB'(t2_a) * PB'(t2_b);

  // Track the previous vertex of the walk
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      wprev_x_q <= last_x_i;
      wprev_y_q <= last_y_i;
    end else if (ctrl_i.rd_valid) begin
      wprev_x_q <= rd_x_i;
      wprev_y_q <= rd_y_i;
    end
  end

  // Stage 1: register the products
  always_ff @(posedge clk_i) begin
    sh_q <= sh_prod;
    m1_q <= m1_prod;
    m2_q <= m2_prod;
  end

  // Stage 2: triangle term magnitude, closing shoelace sum
  assign diff     = (PB + 1)'(m1_q) - (PB + 1)'(m2_q);
  assign diff_abs = diff[PB] ? -diff : diff;

  always_ff @(posedge clk_i) begin
    abs_q <= diff_abs[PB-1:0];
    if (s1_f_q) begin
      sum_q <= part_q + SB'(sh_q);
    end
  end

  // Stage 3: accumulate triangle terms, take the area magnitude
  assign sum_abs = sum_q[SB-1] ? -sum_q : sum_q;

  always_ff @(posedge clk_i) begin
    if (s2_f_q) begin
      area_q <= sum_abs;
    end
  end

  // Hold stage valid bits, the shoelace sum and the triangle sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s1_f_q <= 1'b0;
      s2_v_q <= 1'b0;
      s2_f_q <= 1'b0;
      part_q <= '0;
      tri_q  <= '0;
    end else begin
      s1_v_q <= ctrl_i.rd_valid;
      s1_f_q <= ctrl_i.rd_valid & ctrl_i.rd_first;
      s2_v_q <= s1_v_q;
      s2_f_q <= s1_f_q;
      if (ctrl_i.clr_part) begin
        part_q <= '0;
      end else if (ctrl_i.load_acc) begin
        part_q <= part_q + SB'(sh_q);
      end
      if (ctrl_i.start) begin
        tri_q <= '0;
      end else if (s2_v_q) begin
        tri_q <= tri_q + SB'(abs_q);
      end
    end
  end

  // Compare exactly, saturate the reported area
  assign area_ext = WB'(area_q);

  always_comb begin
    stat_o.busy    = s1_v_q | s2_v_q;
    stat_o.in_poly = (tri_q == area_q);
    if (area_ext > WB'({AB{1'b1}})) begin
      stat_o.area = {AB{1'b1}};
    end else begin
      stat_o.area = area_ext[AB-1:0];
    end
  end

endmodule

FILE: rtl/core/convex_polygon_point_test_unit.sv
// Top level of the convex polygon point test block: sequencer, vertex
// memory and edge datapath. Depends on cppt_pkg, cppt_in_if, cppt_out_if,
// cppt_vertex_store and cppt_edge_unit.
// Usage. Items arrive on in_i. A load (mode 0) appends a vertex; with first
// set it starts a new polygon and clears the sticky overflow flag. A load
// into a full store is dropped and sets that flag. A load gives no result.
// A query (mode 1) gives one transfer on out_o: inside_res, empty_res, the
// overflow flag and the saturated absolute twice-area of the polygon.
// Sequence. A load occupies the input through accept, multiply and add;
// a dropped load ends when it is accepted.
// A query over the stored vertices walks every edge with one vertex memory
// read a cycle, and a three-stage product, magnitude and sum pipeline
// drains before the compare. A query on an empty polygon skips the walk.
// The single read port of the vertex memory sets the walk length.
// The result sits in an output register, so loads go on while it waits;
// a later query waits in its final cycle until the register is free.
// Reset clears the vertex count, the shoelace sum, the overflow flag and
// the output valid; vertex memory contents are not cleared.
module convex_polygon_point_test_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cppt_in_if.sink     in_i,
  cppt_out_if.source  out_o
);

  localparam int AB   = $clog2(MAX_VERTICES);
  localparam int CNTB = $clog2(MAX_VERTICES + 1);
  localparam int ARB  = cppt_pkg::AREA_BITS;

  cppt_pkg::state_e     state_q, state_d;
  cppt_pkg::edge_ctrl_t ctrl;
  cppt_pkg::edge_stat_t stat;

  logic [CNTB-1:0]              count_q, count_d, eff_count;
  logic                         ovf_q, ovf_d;
  logic                         term_q, term_d;
  logic [AB-1:0]                rd_addr_q, rd_addr_d;
  logic                         rd_valid_q, rd_first_q, rd_issue;
  logic                         out_valid_q, out_valid_d, out_set;
  logic                         in_ready, in_fire, full;
  logic                         mem_we, p_load, last_load;
  logic                         empty_q, empty_d;
  logic signed [COORD_BITS-1:0] px_q, py_q, last_x_q, last_y_q;
  logic [2*COORD_BITS-1:0]      rdata;
  logic                         inside_q, empty_res_q, ovf_res_q;
  logic [ARB-1:0]               area_q;

  assign in_fire   = in_i.valid & in_ready;
  assign eff_count = in_i.first ? '0 : count_q;
  assign full      = (eff_count == CNTB'(MAX_VERTICES));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cppt_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == cppt_pkg::MODE_LOAD) begin
            state_d = full ? cppt_pkg::ST_IDLE : cppt_pkg::ST_LOAD_MUL;
          end else begin
            state_d = (count_q == '0) ? cppt_pkg::ST_RESULT : cppt_pkg::ST_WALK;
          end
        end
      end
      cppt_pkg::ST_LOAD_MUL: state_d = cppt_pkg::ST_LOAD_ACC;
      cppt_pkg::ST_LOAD_ACC: state_d = cppt_pkg::ST_IDLE;
      cppt_pkg::ST_WALK: begin
        if (CNTB'(rd_addr_q) + CNTB'(1) == count_q) begin
          state_d = cppt_pkg::ST_DRAIN;
        end
      end
      cppt_pkg::ST_DRAIN: begin
        if (!rd_valid_q && !stat.busy) begin
          state_d = cppt_pkg::ST_RESULT;
        end
      end
      cppt_pkg::ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = cppt_pkg::ST_IDLE;
        end
      end
      default: state_d = cppt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready      = 1'b0;
    count_d       = count_q;
    ovf_d         = ovf_q;
    term_d        = term_q;
    rd_addr_d     = rd_addr_q;
    rd_issue      = 1'b0;
    mem_we        = 1'b0;
    p_load        = 1'b0;
    last_load     = 1'b0;
    empty_d       = empty_q;
    out_set       = 1'b0;
    ctrl          = '0;
    ctrl.rd_valid = rd_valid_q;
    ctrl.rd_first = rd_first_q;
    unique case (state_q)
      cppt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          p_load = 1'b1;
          if (in_i.mode == cppt_pkg::MODE_LOAD) begin
            ctrl.clr_part = in_i.first;
            if (in_i.first) begin
              ovf_d = 1'b0;
            end
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              mem_we  = 1'b1;
              term_d  = (eff_count != '0);
              count_d = eff_count + CNTB'(1);
            end
          end else begin
            empty_d    = (count_q == '0);
            rd_addr_d  = '0;
            ctrl.start = 1'b1;
          end
        end
      end
      cppt_pkg::ST_LOAD_MUL: begin
        ctrl.load_mul = 1'b1;
        last_load     = 1'b1;
      end
      cppt_pkg::ST_LOAD_ACC: begin
        ctrl.load_acc = term_q;
      end
      cppt_pkg::ST_WALK: begin
        rd_issue  = 1'b1;
        rd_addr_d = rd_addr_q + AB'(1);
      end
      cppt_pkg::ST_DRAIN: begin
        rd_issue = 1'b0;
      end
      cppt_pkg::ST_RESULT: begin
        out_set = !out_valid_q || out_o.ready;
      end
      default: begin
        rd_issue = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_set ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cppt_pkg::ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      term_q      <= 1'b0;
      rd_addr_q   <= '0;
      rd_valid_q  <= 1'b0;
      rd_first_q  <= 1'b0;
      out_valid_q <= 1'b0;
      empty_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      term_q      <= term_d;
      rd_addr_q   <= rd_addr_d;
      rd_valid_q  <= rd_issue;
      rd_first_q  <= rd_issue & (rd_addr_q == '0);
      out_valid_q <= out_valid_d;
      empty_q     <= empty_d;
    end
  end

  // Capture the item coordinates and the last stored vertex
  always_ff @(posedge clk_i) begin
    if (p_load) begin
      px_q <= in_i.x;
      py_q <= in_i.y;
    end
    if (last_load) begin
      last_x_q <= px_q;
      last_y_q <= py_q;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (out_set) begin
      inside_q    <= empty_q ? 1'b0 : stat.in_poly;
      area_q      <= empty_q ? '0 : stat.area;
      empty_res_q <= empty_q;
      ovf_res_q   <= ovf_q;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = inside_q;
  assign out_o.empty_res  = empty_res_q;
  assign out_o.overflowed = ovf_res_q;
  assign out_o.twice_area = area_q;

  cppt_vertex_store #(
    .DEPTH     (MAX_VERTICES),
    .DATA_BITS (2 * COORD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (eff_count[AB-1:0]),
    .wdata_i ({in_i.y, in_i.x}),
    .re_i    (rd_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  cppt_edge_unit #(
    .COORD_BITS (COORD_BITS),
    .CNT_BITS   (CNTB)
  ) u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .p_x_i    (px_q),
    .p_y_i    (py_q),
    .last_x_i (last_x_q),
    .last_y_i (last_y_q),
    .rd_x_i   (rdata[COORD_BITS-1:0]),
    .rd_y_i   (rdata[2*COORD_BITS-1:COORD_BITS]),
    .stat_o   (stat)
  );

  // The vertex count never passes the store depth
  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      count_q <= CNTB'(MAX_VERTICES);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("vertex count past depth");

  // Overflow is only flagged with a full store
  property p_ovf_full;
    @(posedge clk_i) disable iff (!rst_ni)
      ovf_q |-> (count_q == CNTB'(MAX_VERTICES));
  endproperty
  a_ovf_full: assert property (p_ovf_full) else $error("overflow without full store");

  // An empty query reports neither inside nor area
  property p_empty_result;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && empty_res_q) |-> (!inside_q && area_q == '0);
  endproperty
  a_empty_result: assert property (p_empty_result) else $error("empty result not cleared");

  // Every vertex read enters the edge pipeline
  property p_read_enters;
    @(posedge clk_i) disable iff (!rst_ni)
      rd_valid_q |=> stat.busy;
  endproperty
  a_read_enters: assert property (p_read_enters) else $error("vertex read lost");

endmodule

FILE: test/tb_convex_polygon_point_test_unit.sv
// Testbench for convex_polygon_point_test_unit: loads polygons, queries points
// and checks each result against a scoreboard that predicts it.
// Depends on cppt_pkg, cppt_in_if, cppt_out_if and the block itself.
module tb_convex_polygon_point_test_unit;

  localparam int CW          = 16;
  localparam int NV          = 64;
  localparam int LONG_HOLD   = 400;
  localparam int ITEM_BUDGET = 1900;
  localparam longint AREA_TOP = (longint'(1) << cppt_pkg::AREA_BITS) - 1;

  typedef struct packed {
    logic                 mode;
    logic                 first;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } item_t;

  typedef struct packed {
    logic                           in_poly;
    logic                           empty;
    logic                           ovf;
    logic [cppt_pkg::AREA_BITS-1:0] area;
  } verdict_t;

  // Polygon state mirror and store of verdicts still to arrive
  class point_test_scoreboard;
    int          vx[NV];
    int          vy[NV];
    int unsigned n_vert;
    longint      shoelace;
    bit          ovf;
    verdict_t    due[$];
    int          errors;

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Update the polygon on a load; work out the verdict of a query
    function void absorb_item(item_t it);
      longint      px, py, area2, tri_sum, xj, yj, xi, yi;
      int unsigned j;
      verdict_t    v;
      px = $signed(it.x);
      py = $signed(it.y);
      if (it.mode == cppt_pkg::MODE_LOAD) begin
        if (it.first) begin
          n_vert   = 0;
          shoelace = 0;
          ovf      = 1'b0;
        end
        if (n_vert >= NV) begin
          ovf = 1'b1;
          return;
        end
        if (n_vert > 0)
          shoelace += (longint'(vx[n_vert-1]) + px) * (longint'(vy[n_vert-1]) - py);
        vx[n_vert] = int'(px);
        vy[n_vert] = int'(py);
        n_vert++;
        return;
      end
      v.ovf = ovf;
      if (n_vert == 0) begin
        v.in_poly = 1'b0;
        v.empty   = 1'b1;
        v.area    = '0;
      end else begin
        // close the shoelace with the edge from the last vertex to vertex 0
        area2 = mag(shoelace + (longint'(vx[n_vert-1]) + vx[0]) *
                               (longint'(vy[n_vert-1]) - vy[0]));
        tri_sum = 0;
        j = n_vert - 1;
        for (int unsigned i = 0; i < n_vert; i++) begin
          xj = vx[j];
          yj = vy[j];
          xi = vx[i];
          yi = vy[i];
          tri_sum += mag((xj - px) * (yi - yj) - (xj - xi) * (py - yj));
          j = i;
        end
        v.in_poly = (tri_sum == area2);
        v.empty   = 1'b0;
        v.area    = (area2 > AREA_TOP) ? AREA_TOP[cppt_pkg::AREA_BITS-1:0]
                                       : area2[cppt_pkg::AREA_BITS-1:0];
      end
      due.push_back(v);
    endfunction

    // Compare a delivered verdict with the oldest one predicted
    task compare_verdict(verdict_t got);
      verdict_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: in=%0d empty=%0d ovf=%0d area=%0d",
                                  got.in_poly, got.empty, got.ovf, got.area));
        return;
      end
      want = due.pop_front();
      if (got.in_poly !== want.in_poly)
        report_mismatch($sformatf("inside_res %0d, want %0d", got.in_poly, want.in_poly));
      if (got.empty !== want.empty)
        report_mismatch($sformatf("empty_res %0d, want %0d", got.empty, want.empty));
      if (got.ovf !== want.ovf)
        report_mismatch($sformatf("overflowed %0d, want %0d", got.ovf, want.ovf));
      if (got.area !== want.area)
        report_mismatch($sformatf("twice_area %0d, want %0d", got.area, want.area));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cppt_in_if #(.COORD_BITS(CW)) in_if ();
  cppt_out_if                   out_if ();

  convex_polygon_point_test_unit #(
    .MAX_VERTICES(NV),
    .COORD_BITS  (CW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  point_test_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int items_sent = 0;
  int shape_x[$];
  int shape_y[$];
  verdict_t seen;

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Drive ready: random stalls, or a long hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = LONG_HOLD - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Check each result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.in_poly = out_if.inside_res;
      seen.empty   = out_if.empty_res;
      seen.ovf     = out_if.overflowed;
      seen.area    = out_if.twice_area;
      sb.compare_verdict(seen);
    end
  end

  function automatic int clip(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int near(int c, int s);
    return clip(c + int'($urandom_range(0, 2 * s)) - s);
  endfunction

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic mode, input logic first, input int x, input int y);
    item_t it;
    it.mode  = mode;
    it.first = first;
    it.x     = x[CW-1:0];
    it.y     = y[CW-1:0];
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= it.mode;
    in_if.first <= it.first;
    in_if.x     <= it.x;
    in_if.y     <= it.y;
    do @(posedge clk_i); while (!in_if.ready);
    sb.absorb_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_vertex(input logic first, input int x, input int y);
    send_item(cppt_pkg::MODE_LOAD, first, x, y);
  endtask

  task automatic ask_point(input int x, input int y);
    send_item(cppt_pkg::MODE_QUERY, ($urandom_range(7) == 0), x, y);
  endtask

  // Load the shape held in shape_x/shape_y, starting a new polygon if fresh
  task automatic load_shape(input bit fresh);
    for (int k = 0; k < shape_x.size(); k++)
      load_vertex(fresh && (k == 0), shape_x[k], shape_y[k]);
  endtask

  // Full-range square wound round past capacity: saturates the area and
  // drops the last loads, then a new polygon clears the sticky flag
  task automatic wind_extreme_square();
    int cx[4] = '{-32768, 32767, 32767, -32768};
    int cy[4] = '{-32768, -32768, 32767, 32767};
    for (int k = 0; k < NV + 2; k++)
      load_vertex(k == 0, cx[k % 4], cy[k % 4]);
    ask_point(0, 0);
    ask_point(32767, 32767);
    load_vertex(1'b1, -5, -5);
    load_vertex(1'b0, 5, -5);
    load_vertex(1'b0, 0, 5);
    ask_point(0, 0);
  endtask

  // One random polygon, or an append to the current one, then a few queries
  task automatic random_polygon();
    int  kind, n, cx, cy, s, x0, x1, y0, y1, d, e, k, sx, sy;
    bit  fresh;
    kind  = $urandom_range(0, 19);
    fresh = 1'b1;
    case ($urandom_range(0, 3))
      0: s = 8;
      1: s = 300;
      2: s = 20000;
      default: s = 65535;
    endcase
    cx = any_coord();
    cy = any_coord();
    if (kind == 18 && shape_x.size() > 0) begin
      // append to the current polygon without starting a new one
      fresh = 1'b0;
      shape_x.delete();
      shape_y.delete();
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) begin
        shape_x.push_back(near(cx, s));
        shape_y.push_back(near(cy, s));
      end
    end else begin
      shape_x.delete();
      shape_y.delete();
      if (kind >= 9 && kind <= 12) begin
        x0 = near(cx, s); x1 = near(cx, s); y0 = near(cy, s); y1 = near(cy, s);
        shape_x = '{x0, x1, x1, x0};
        shape_y = '{y0, y0, y1, y1};
      end else if (kind == 16) begin
        d = $urandom_range(0, 2 * s) - s;
        e = $urandom_range(0, 2 * s) - s;
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          shape_x.push_back(clip(cx + k * d));
          shape_y.push_back(clip(cy + k * e));
        end
      end else if (kind == 17) begin
        d = $urandom_range(0, s / 2);
        shape_x = '{clip(cx - 2*d), clip(cx - d), clip(cx + d), clip(cx + 2*d),
                    clip(cx + d), clip(cx - d)};
        shape_y = '{cy, clip(cy - d), clip(cy - d), cy, clip(cy + d), clip(cy + d)};
      end else begin
        if (kind >= 13 && kind <= 15) n = $urandom_range(4, 8);
        else if (kind == 19 && $urandom_range(0, 3) == 0) n = $urandom_range(60, 70);
        else n = 3;
        for (k = 0; k < n; k++) begin
          shape_x.push_back(near(cx, s));
          shape_y.push_back(near(cy, s));
        end
      end
    end
    load_shape(fresh);

    n = $urandom_range(1, 4);
    for (int q = 0; q < n; q++) begin
      sx = 0;
      sy = 0;
      foreach (shape_x[i]) begin
        sx += shape_x[i];
        sy += shape_y[i];
      end
      sx = sx / shape_x.size();
      sy = sy / shape_y.size();
      k = $urandom_range(0, shape_x.size() - 1);
      case ($urandom_range(0, 5))
        0: ask_point(shape_x[k], shape_y[k]);
        1: ask_point(sx, sy);
        2: ask_point((shape_x[k] + shape_x[(k + 1) % shape_x.size()]) / 2,
                     (shape_y[k] + shape_y[(k + 1) % shape_y.size()]) / 2);
        3: ask_point(near(cx, s), near(cy, s));
        4: ask_point(any_coord(), any_coord());
        default: ask_point(clip(sx + $urandom_range(0, 2) - 1),
                           clip(sy + $urandom_range(0, 2) - 1));
      endcase
    end
  endtask

  // Timeout
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.mode   = cppt_pkg::MODE_LOAD;
    in_if.first  = 1'b0;
    in_if.x      = '0;
    in_if.y      = '0;
    out_if.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty query, load onto an empty store, a single vertex
    ask_point(0, 0);
    load_vertex(1'b0, 7, -3);
    ask_point(7, -3);
    ask_point(8, -3);
    // Small square: inside, on an edge, at a vertex, just outside
    load_vertex(1'b1, -100, -100);
    load_vertex(1'b0, 100, -100);
    load_vertex(1'b0, 100, 100);
    load_vertex(1'b0, -100, 100);
    ask_point(0, 0);
    ask_point(100, 0);
    ask_point(-100, -100);
    ask_point(101, 0);
    send_item(cppt_pkg::MODE_QUERY, 1'b1, 0, 0);
    // Full-range square
    load_vertex(1'b1, -32768, -32768);
    load_vertex(1'b0, 32767, -32768);
    load_vertex(1'b0, 32767, 32767);
    load_vertex(1'b0, -32768, 32767);
    ask_point(32767, 32767);
    ask_point(-32768, 0);
    // Collinear vertices: zero area
    load_vertex(1'b1, 0, 0);
    load_vertex(1'b0, 10, 10);
    load_vertex(1'b0, 20, 20);
    ask_point(5, 5);
    ask_point(5, 6);

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
        default: begin src_idle_pct = 13; snk_stall_pct = 13; end
      endcase
      if (ph == 0 || ph == 3)
        hold_asked++;
      if (ph == 1)
        wind_extreme_square();
      while (items_sent < (ph + 1) * ITEM_BUDGET / 4)
        random_polygon();
    end
    in_if.valid <= 1'b0;

    // Drain, then allow for any stray result
    while (sb.due.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cppt_pkg.sv
rtl/core/cppt_in_if.sv
rtl/core/cppt_out_if.sv
rtl/core/cppt_vertex_store.sv
rtl/core/cppt_edge_unit.sv
rtl/core/convex_polygon_point_test_unit.sv
test/tb_convex_polygon_point_test_unit.sv
